@@ hw/rtl/dis_pkg.sv @@
// ----------------------------------------------------------------------------
// dis_pkg
// shared constants and codes of the interval set block
// ----------------------------------------------------------------------------
package dis_pkg;

    localparam int MaxRanges = 16;
    localparam int IdxW      = $clog2(MaxRanges);
    localparam int CountW    = $clog2(MaxRanges + 1);
    localparam int InW       = 104;
    localparam int OutW      = 72;

    typedef enum logic [2:0] {
        ACT_ADD       = 3'd0,
        ACT_SUB       = 3'd1,
        ACT_INTERSECT = 3'd2,
        ACT_CONTAINS  = 3'd3,
        ACT_SHIFT_FWD = 3'd4,
        ACT_SHIFT_BK  = 3'd5,
        ACT_READ      = 3'd6,
        ACT_NONE      = 3'd7
    } action_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_SPLIT = 5'b01000,
        ST_TAIL  = 5'b10000
    } state_t;

endpackage

@@ hw/rtl/disjoint_interval_set.sv @@
// ----------------------------------------------------------------------------
// disjoint_interval_set
// sorted table of disjoint inclusive ranges with add, subtract, intersect,
// point test, shift and indexed read
// ----------------------------------------------------------------------------
// One beat in, one beat out. The ranges live in two banks of a bound memory;
// an action walks the current bank one entry per cycle, pausing for each split
// or inserted range, and writes the new table into the other bank, which then
// becomes current; the single read port walking the table sets the pace. A
// beat is taken whenever the block is idle, but the action only finishes once
// the result register is free.
module disjoint_interval_set (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // action[2:0], range_low[34:3], range_high[66:35], amount[98:67],
    // entry_index[102:99], zero[103]
    input  logic [dis_pkg::InW-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // hit[0], entry_valid[1], entry_low[33:2], entry_high[65:34],
    // range_count[70:66], overflow[71]
    output logic [dis_pkg::OutW-1:0] m_tdata
);
    import dis_pkg::*;

    localparam logic [31:0] UMax = 32'hffff_ffff;

    // two banks, bank select in the top address bit
    logic [31:0] mem_lo [2*MaxRanges];
    logic [31:0] mem_hi [2*MaxRanges];
    logic [31:0] rd_lo_reg, rd_hi_reg;

    state_t           state_reg, state_next;
    action_t          act_reg, act_next;
    logic [31:0]      a_reg, a_next, b_reg, b_next, v_reg, v_next;
    logic [31:0]      pend_lo_reg, pend_lo_next, pend_hi_reg, pend_hi_next;
    logic [IdxW-1:0]  idx_reg, idx_next;
    logic [CountW-1:0] count_reg, count_next, wn_reg, wn_next;
    logic             bank_reg, bank_next;
    logic             ins_reg, ins_next, spill_reg, spill_next;
    logic             skip_reg, skip_next;
    logic             hit_reg, hit_next;
    logic             m_valid_reg, m_valid_next;
    logic [OutW-1:0]  m_data_reg, m_data_next;

    logic             emit;
    logic [31:0]      emit_lo, emit_hi;
    logic             advance;
    logic             last;
    logic [31:0]      l, h, cap_lo, cap_hi;
    logic             rd_valid;
    logic             commit;

    assign l = rd_lo_reg;
    assign h = rd_hi_reg;
    assign last = ({1'b0, idx_reg} + CountW'(1)) >= count_reg;
    assign cap_lo = (l > a_reg) ? l : a_reg;
    assign cap_hi = (h < b_reg) ? h : b_reg;
    assign rd_valid = {1'b0, idx_reg} < count_reg;
    assign commit = !skip_reg && (act_reg == ACT_ADD || act_reg == ACT_SUB ||
        act_reg == ACT_INTERSECT || act_reg == ACT_SHIFT_FWD ||
        act_reg == ACT_SHIFT_BK);

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        v_next       = v_reg;
        pend_lo_next = pend_lo_reg;
        pend_hi_next = pend_hi_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        wn_next      = wn_reg;
        bank_next    = bank_reg;
        ins_next     = ins_reg;
        spill_next   = spill_reg;
        skip_next    = skip_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        emit         = 1'b0;
        emit_lo      = l;
        emit_hi      = h;
        advance      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = action_t'(s_tdata[2:0]);
                    a_next     = s_tdata[34:3];
                    b_next     = s_tdata[66:35];
                    v_next     = s_tdata[98:67];
                    wn_next    = '0;
                    ins_next   = 1'b0;
                    spill_next = 1'b0;
                    hit_next   = 1'b0;
                    skip_next  = (s_tdata[2:0] <= 3'(ACT_INTERSECT)) &&
                                 (s_tdata[34:3] > s_tdata[66:35]);
                    if (action_t'(s_tdata[2:0]) == ACT_READ) begin
                        idx_next   = s_tdata[102:99];
                        state_next = ST_LOAD;
                    end else begin
                        idx_next   = '0;
                        state_next = (count_reg == '0 || skip_next ||
                                      action_t'(s_tdata[2:0]) == ACT_NONE)
                                     ? ST_TAIL : ST_LOAD;
                    end
                end
            end
            ST_LOAD: state_next = ST_WALK;
            ST_WALK: begin
                advance = 1'b1;
                unique case (act_reg)
                    ACT_ADD: begin
                        if (h != UMax && h + 32'd1 < a_reg) begin
                            emit = 1'b1;
                        end else if (b_reg != UMax && b_reg + 32'd1 < l) begin
                            if (!ins_reg) begin
                                // new range goes first, stored entry next cycle
                                emit         = 1'b1;
                                emit_lo      = a_reg;
                                emit_hi      = b_reg;
                                ins_next     = 1'b1;
                                pend_lo_next = l;
                                pend_hi_next = h;
                                advance      = 1'b0;
                                state_next   = ST_SPLIT;
                            end else begin
                                emit = 1'b1;
                            end
                        end else begin
                            if (l < a_reg) a_next = l;
                            if (h > b_reg) b_next = h;
                        end
                    end
                    ACT_SUB: begin
                        if (h < a_reg || l > b_reg) begin
                            emit = 1'b1;
                        end else if (l < a_reg) begin
                            emit    = 1'b1;
                            emit_hi = a_reg - 32'd1;
                            if (h > b_reg) begin
                                pend_lo_next = b_reg + 32'd1;
                                pend_hi_next = h;
                                advance      = 1'b0;
                                state_next   = ST_SPLIT;
                            end
                        end else if (h > b_reg) begin
                            emit    = 1'b1;
                            emit_lo = b_reg + 32'd1;
                        end
                    end
                    ACT_INTERSECT: begin
                        emit    = cap_lo <= cap_hi;
                        emit_lo = cap_lo;
                        emit_hi = cap_hi;
                    end
                    ACT_CONTAINS: begin
                        if (v_reg >= l && v_reg <= h) hit_next = 1'b1;
                    end
                    ACT_SHIFT_FWD: begin
                        if (l > ~v_reg) begin
                            // everything above drops too
                            advance    = 1'b0;
                            state_next = ST_TAIL;
                        end else begin
                            emit    = 1'b1;
                            emit_lo = l + v_reg;
                            emit_hi = (h > ~v_reg) ? UMax : h + v_reg;
                        end
                    end
                    ACT_SHIFT_BK: begin
                        emit    = h >= v_reg;
                        emit_lo = (l < v_reg) ? 32'd0 : l - v_reg;
                        emit_hi = h - v_reg;
                    end
                    ACT_READ: begin
                        advance    = 1'b0;
                        state_next = ST_TAIL;
                    end
                    default: begin
                        advance    = 1'b0;
                        state_next = ST_TAIL;
                    end
                endcase
            end
            ST_SPLIT: begin
                emit    = 1'b1;
                emit_lo = pend_lo_reg;
                emit_hi = pend_hi_reg;
                advance = 1'b1;
            end
            ST_TAIL: begin
                if (!m_valid_reg || m_tready) begin
                    if (act_reg == ACT_ADD && !skip_reg && !ins_reg) begin
                        emit    = 1'b1;
                        emit_lo = a_reg;
                        emit_hi = b_reg;
                    end
                    if (commit) begin
                        bank_next  = !bank_reg;
                        count_next = (emit && wn_reg < CountW'(MaxRanges))
                                     ? wn_reg + CountW'(1) : wn_reg;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[0] = (act_reg == ACT_CONTAINS) && hit_reg;
                    if (act_reg == ACT_READ && rd_valid) begin
                        m_data_next[1]     = 1'b1;
                        m_data_next[33:2]  = l;
                        m_data_next[65:34] = h;
                    end
                    m_data_next[70:66] = count_next;
                    m_data_next[71]    = spill_reg ||
                                         (emit && wn_reg >= CountW'(MaxRanges));
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (advance) begin
            if (last) begin
                state_next = ST_TAIL;
            end else begin
                idx_next   = idx_reg + IdxW'(1);
                state_next = ST_WALK;
            end
        end

        if (emit && state_reg != ST_TAIL) begin
            if (wn_reg < CountW'(MaxRanges)) wn_next = wn_reg + CountW'(1);
            else spill_next = 1'b1;
        end
    end

    // table banks: write the other bank, read the current one
    always_ff @(posedge aclk) begin
        if (emit && wn_reg < CountW'(MaxRanges)) begin
            mem_lo[{!bank_reg, wn_reg[IdxW-1:0]}] <= emit_lo;
            mem_hi[{!bank_reg, wn_reg[IdxW-1:0]}] <= emit_hi;
        end
        rd_lo_reg <= mem_lo[{bank_reg, idx_next}];
        rd_hi_reg <= mem_hi[{bank_reg, idx_next}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            wn_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            bank_reg    <= bank_next;
            m_valid_reg <= m_valid_next;
            wn_reg      <= wn_next;
        end
        act_reg     <= act_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        v_reg       <= v_next;
        pend_lo_reg <= pend_lo_next;
        pend_hi_reg <= pend_hi_next;
        idx_reg     <= idx_next;
        ins_reg     <= ins_next;
        spill_reg   <= spill_next;
        skip_reg    <= skip_next;
        hit_reg     <= hit_next;
        m_data_reg  <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountW'(MaxRanges))
        else $error("stored range count beyond table size");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[71] |-> m_tdata[70:66] == CountW'(MaxRanges))
        else $error("overflow reported with table not full");

    a_hit_read_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("hit and entry valid in one beat");

    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        bank_reg != $past(bank_reg) |-> $past(state_reg) == ST_TAIL)
        else $error("bank switched outside of commit");

endmodule

@@ verif/tb_disjoint_interval_set.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_disjoint_interval_set
// self-checking bench for the interval set block: directed actions, an
// overflowing table, receiver back-pressure and a long random mix, with
// every result compared against an in-bench model of the range table
// ----------------------------------------------------------------------------
module tb_disjoint_interval_set;
    import dis_pkg::*;

    localparam logic [31:0] TopVal = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        overflow;
        logic [4:0]  range_count;
        logic [31:0] entry_high;
        logic [31:0] entry_low;
        logic        entry_valid;
        logic        hit;
    } outcome_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [InW-1:0]  s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [OutW-1:0] m_tdata;

    // model copy of the range table
    logic [31:0] tab_lo [MaxRanges];
    logic [31:0] tab_hi [MaxRanges];
    int          tab_cnt;
    logic [31:0] nxt_lo [MaxRanges];
    logic [31:0] nxt_hi [MaxRanges];
    int          nxt_cnt;
    bit          spilled;

    outcome_t pending_outcomes [$];
    int  mismatches = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  overflows_seen = 0;
    bit  idle_on = 1'b1;
    int  rx_hold = 0;

    disjoint_interval_set dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic void emit_range(input logic [31:0] lo, input logic [31:0] hi);
        if (nxt_cnt < MaxRanges) begin
            nxt_lo[nxt_cnt] = lo;
            nxt_hi[nxt_cnt] = hi;
            nxt_cnt++;
        end else begin
            spilled = 1'b1;
        end
    endfunction

    function automatic outcome_t apply_action(input action_t act, input logic [31:0] a_in,
                                              input logic [31:0] b_in, input logic [31:0] v,
                                              input logic [3:0] idx);
        outcome_t    r;
        logic [31:0] a, b, l, h, lo, hi;
        bit          ins;
        bit          update;
        r = '0;
        a = a_in;
        b = b_in;
        ins = 1'b0;
        update = 1'b0;
        nxt_cnt = 0;
        spilled = 1'b0;
        for (int k = 0; k < MaxRanges; k++) begin
            nxt_lo[k] = '0;
            nxt_hi[k] = '0;
        end
        case (act)
            ACT_ADD: if (a <= b) begin
                for (int i = 0; i < tab_cnt; i++) begin
                    l = tab_lo[i];
                    h = tab_hi[i];
                    if (h != TopVal && h + 32'd1 < a) begin
                        emit_range(l, h);
                    end else if (b != TopVal && b + 32'd1 < l) begin
                        if (!ins) begin
                            emit_range(a, b);
                            ins = 1'b1;
                        end
                        emit_range(l, h);
                    end else begin
                        if (l < a) a = l;
                        if (h > b) b = h;
                    end
                end
                if (!ins) emit_range(a, b);
                update = 1'b1;
            end
            ACT_SUB: if (a <= b) begin
                for (int i = 0; i < tab_cnt; i++) begin
                    l = tab_lo[i];
                    h = tab_hi[i];
                    if (h < a || l > b) begin
                        emit_range(l, h);
                    end else begin
                        if (l < a) emit_range(l, a - 32'd1);
                        if (h > b) emit_range(b + 32'd1, h);
                    end
                end
                update = 1'b1;
            end
            ACT_INTERSECT: if (a <= b) begin
                for (int i = 0; i < tab_cnt; i++) begin
                    lo = (tab_lo[i] > a) ? tab_lo[i] : a;
                    hi = (tab_hi[i] < b) ? tab_hi[i] : b;
                    if (lo <= hi) emit_range(lo, hi);
                end
                update = 1'b1;
            end
            ACT_CONTAINS: begin
                for (int i = 0; i < tab_cnt; i++)
                    if (v >= tab_lo[i] && v <= tab_hi[i]) r.hit = 1'b1;
            end
            ACT_SHIFT_FWD: begin
                for (int i = 0; i < tab_cnt; i++) begin
                    l = tab_lo[i];
                    h = tab_hi[i];
                    // low end would wrap: this and every higher range go
                    if (l > TopVal - v) break;
                    emit_range(l + v, (h > TopVal - v) ? TopVal : h + v);
                end
                update = 1'b1;
            end
            ACT_SHIFT_BK: begin
                for (int i = 0; i < tab_cnt; i++) begin
                    l = tab_lo[i];
                    h = tab_hi[i];
                    if (h >= v) emit_range((l < v) ? 32'd0 : l - v, h - v);
                end
                update = 1'b1;
            end
            ACT_READ: if (idx < tab_cnt) begin
                r.entry_valid = 1'b1;
                r.entry_low   = tab_lo[idx];
                r.entry_high  = tab_hi[idx];
            end
            default: ;
        endcase
        if (update) begin
            tab_lo  = nxt_lo;
            tab_hi  = nxt_hi;
            tab_cnt = nxt_cnt;
        end
        r.range_count = tab_cnt[4:0];
        r.overflow    = spilled;
        return r;
    endfunction

    task automatic send_beat(input action_t act, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] v, input logic [3:0] idx);
        int       gap;
        outcome_t exp_beat;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, idx, v, b, a, act};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        exp_beat = apply_action(act, a, b, v, idx);
        pending_outcomes.insert(pending_outcomes.size(), exp_beat);
        beats_in++;
    endtask

    // receiver: random stall per beat, plus a long hold-off when a test asks for one
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge aclk);
                rx_hold = 0;
            end
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin
        outcome_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = outcome_t'(m_tdata);
            beats_out++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end else begin
                want = pending_outcomes.pop_front();
                if (want.overflow) overflows_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch beat %0d: exp hit=%b ev=%b lo=%h hi=%h cnt=%0d ",
                                  "ovf=%b, got hit=%b ev=%b lo=%h hi=%h cnt=%0d ovf=%b"},
                                 beats_out, want.hit, want.entry_valid, want.entry_low,
                                 want.entry_high, want.range_count, want.overflow,
                                 got.hit, got.entry_valid, got.entry_low, got.entry_high,
                                 got.range_count, got.overflow);
                end
            end
        end
    end

    task automatic test_basic_actions();
        send_beat(ACT_ADD, 32'd10, 32'd20, 0, 0);
        send_beat(ACT_ADD, 32'd22, 32'd30, 0, 0);
        send_beat(ACT_CONTAINS, 0, 0, 32'd21, 0);
        send_beat(ACT_ADD, 32'd21, 32'd21, 0, 0);     // adjoins both sides
        send_beat(ACT_ADD, 32'd50, 32'd40, 0, 0);     // reversed, ignored
        send_beat(ACT_CONTAINS, 0, 0, 32'd30, 0);
        send_beat(ACT_CONTAINS, 0, 0, 32'd31, 0);
        send_beat(ACT_SUB, 32'd12, 32'd14, 0, 0);     // splits one entry
        send_beat(ACT_SUB, 32'd9, 32'd5, 0, 0);
        send_beat(ACT_INTERSECT, 32'd11, 32'd25, 0, 0);
        send_beat(ACT_INTERSECT, 32'd30, 32'd20, 0, 0);
        send_beat(ACT_READ, 0, 0, 0, 4'd1);
        send_beat(ACT_SHIFT_FWD, 0, 0, 32'd5, 0);
        send_beat(ACT_SHIFT_BK, 0, 0, 32'd18, 0);     // drops the lower range
        send_beat(ACT_READ, 0, 0, 0, 4'd0);
        send_beat(ACT_READ, 0, 0, 0, 4'd15);
        send_beat(ACT_NONE, TopVal, TopVal, TopVal, 4'hF);
        send_beat(ACT_SHIFT_BK, 0, 0, TopVal, 0);     // drops everything
    endtask

    task automatic test_extremes();
        send_beat(ACT_ADD, 32'd0, 32'd0, 0, 0);
        send_beat(ACT_ADD, TopVal, TopVal, 0, 0);
        send_beat(ACT_SHIFT_FWD, 0, 0, 32'd1, 0);    // top end wraps, dropped
        send_beat(ACT_ADD, TopVal - 1, TopVal, 0, 0);
        send_beat(ACT_SHIFT_FWD, 0, 0, 32'd1, 0);    // high end saturates
        send_beat(ACT_ADD, 32'd0, TopVal, 0, 0);
        send_beat(ACT_SUB, 32'd0, 32'd0, 0, 0);
        send_beat(ACT_SUB, TopVal, TopVal, 0, 0);
        send_beat(ACT_SHIFT_FWD, 0, 0, TopVal, 0);
        send_beat(ACT_INTERSECT, 32'd0, TopVal, 0, 0);
        send_beat(ACT_SUB, 32'd0, TopVal, 0, 0);
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MaxRanges + 2; i++)
            send_beat(ACT_ADD, 32'(i * 4), 32'(i * 4 + 1), 0, 0);
        for (int i = 0; i < MaxRanges; i++)
            send_beat(ACT_READ, 0, 0, 0, 4'(i));
        send_beat(ACT_SUB, 32'd5, 32'd5, 0, 0);       // trims one entry of a full table
        send_beat(ACT_SHIFT_BK, 0, 0, 32'd30, 0);
    endtask

    task automatic test_backpressure();
        rx_hold = 300;
        for (int i = 0; i < 12; i++)
            send_beat(ACT_ADD, 32'(1000 + i * 8), 32'(1003 + i * 8), 0, 0);
    endtask

    function automatic logic [31:0] pick_value(input int mode, input logic [31:0] base);
        case (mode)
            0: return base + $urandom_range(0, 255);
            1: return TopVal - $urandom_range(0, 255);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_random_mix(input int count);
        int          mode, sel;
        logic [31:0] a, b, base;
        action_t     act;
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 100) idle_on = 1'b0;
            if (i % 200 == 160) idle_on = 1'b1;
            mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
            base = (mode == 0) ? 32'($urandom_range(0, 3)) << 30 : 32'd0;
            sel  = $urandom_range(0, 99);
            act  = sel < 35 ? ACT_ADD : sel < 52 ? ACT_SUB : sel < 57 ? ACT_INTERSECT :
                   sel < 70 ? ACT_CONTAINS : sel < 75 ? ACT_SHIFT_FWD :
                   sel < 80 ? ACT_SHIFT_BK : sel < 97 ? ACT_READ : ACT_NONE;
            a = pick_value(mode, base);
            b = ($urandom_range(0, 9) == 0) ? pick_value(mode, base)
                : a + $urandom_range(0, (mode == 0) ? 24 : 1 << 20);
            if (b < a && $urandom_range(0, 3) != 0) b = TopVal;
            if (act == ACT_INTERSECT && $urandom_range(0, 1)) begin
                a = base;
                b = base + 200;
            end
            send_beat(act, a, b,
                      (act == ACT_CONTAINS) ? pick_value(mode, base)
                      : (mode == 2 ? $urandom() : $urandom_range(0, 64)),
                      4'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        tab_cnt = 0;
        @(posedge aclk);
        test_basic_actions();
        test_extremes();
        test_overflow();
        test_backpressure();
        test_random_mix(900);
        s_tvalid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        repeat (60) @(posedge aclk);
        $display("covered %0d action beats, %0d results, %0d with table overflow",
                 beats_in, beats_out, overflows_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("PASS disjoint_interval_set");
        else
            $display("FAIL disjoint_interval_set");
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout, %0d results outstanding", pending_outcomes.size());
        $display("FAIL disjoint_interval_set");
        $finish;
    end

endmodule
